/* sv/assert_macros.svh */
// Assertion macros shared by the sender window RTL.
// No dependencies; the bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GBN_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define GBN_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GBN_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GBN_ASSERT(lbl, clk, rst, prop)
`define GBN_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define GBN_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* sv/gbn_pkg.sv */
// Types and constants for the go-back-N sender window.
// No dependencies.
package gbn_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int WIN_W      = 7;
  localparam int SEQ_W      = 24;
  localparam int TIME_W     = 48;
  localparam int TX_W       = 40;
  localparam int RTT_W      = 63;

  localparam logic [SEQ_W-1:0] TOTAL_RESET  = 24'd250000;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd50;

  localparam logic REG_TOTAL  = 1'b0;
  localparam logic REG_WINDOW = 1'b1;

  typedef enum logic [1:0] {
    OP_POLL    = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2
  } op_t;

endpackage

/* sv/go_back_n_sender_window.sv */
// Go-back-N sender window for a fixed number of packets, with a send stamp
// memory. Depends on gbn_pkg and assert_macros.svh.
//
// Each input beat is a fill poll, a cumulative ack or a timeout. The block takes
// one beat and then stays busy until its last result sits in the output register.
// An ack that covers N packets walks their stamps through the single read port
// of the stamp memory, one stamp a cycle. Then the block sends packets, up to
// the window; an event that sends nothing yields one status beat. Stalls on
// the output hold the sending.
module go_back_n_sender_window (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [71:0]  s_tdata,   // ack_seq[23:0], now_us[71:24]
  input  logic [1:0]   s_tuser,   // op[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [151:0] m_tdata,   // send_seq[23:0], sent_count[63:24],
                                  // acked_count[87:64], rtt_sum_us[150:88],
                                  // all_acked[151]
  output logic [0:0]   m_tuser,   // send_valid[0]
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [23:0]  cfg_data
);

  `include "assert_macros.svh"

  localparam int SEQ_W  = gbn_pkg::SEQ_W;
  localparam int TIME_W = gbn_pkg::TIME_W;
  localparam int SLOT_W = gbn_pkg::SLOT_W;
  localparam int WIN_W  = gbn_pkg::WIN_W;
  localparam int TX_W   = gbn_pkg::TX_W;
  localparam int RTT_W  = gbn_pkg::RTT_W;

  typedef enum logic [1:0] {ST_IDLE, ST_ACK, ST_SEND} state_t;

  state_t              state;
  logic [SEQ_W-1:0]    total_packets;
  logic [WIN_W-1:0]    win_limit;
  logic [SEQ_W-1:0]    base_seq;
  logic [SEQ_W-1:0]    next_seq;
  logic [TX_W-1:0]     transmit_total;
  logic [SEQ_W-1:0]    ack_total;
  logic [RTT_W-1:0]    round_trip_sum;
  logic [TIME_W-1:0]   req_now;
  logic [SEQ_W-1:0]    ack_end;
  logic [SLOT_W-1:0]   rd_ptr;
  logic [WIN_W-1:0]    rd_left;
  logic                rd_v;
  logic                rtt_v;
  logic [TIME_W-1:0]   rd_data;
  logic [TIME_W-1:0]   rtt;
  logic [TIME_W-1:0]   stamp_mem [gbn_pkg::MAX_WINDOW];

  logic [SEQ_W-1:0]    in_ack;
  logic [TIME_W-1:0]   in_now;
  gbn_pkg::op_t        in_op;
  logic                in_take;
  logic                ack_ok;
  logic [SEQ_W-1:0]    ack_span;
  logic [WIN_W-1:0]    win;
  logic [SEQ_W-1:0]    outstanding;
  logic [SEQ_W:0]      next_inc;
  logic                send_now;
  logic                send_after;
  logic                slot_free;
  logic                stamp_we;
  logic [TX_W-1:0]     tx_next;
  logic [SEQ_W-1:0]    ack_total_next;
  logic [RTT_W:0]      rtt_add;

  assign in_ack    = s_tdata[23:0];
  assign in_now    = s_tdata[71:24];
  assign in_op     = gbn_pkg::op_t'(s_tuser);
  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_take   = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;

  assign ack_ok   = (in_ack >= base_seq) && (in_ack < total_packets) && (in_ack < next_seq);
  assign ack_span = in_ack - base_seq;

  assign win         = (win_limit > WIN_W'(gbn_pkg::MAX_WINDOW))
                       ? WIN_W'(gbn_pkg::MAX_WINDOW) : win_limit;
  assign outstanding = next_seq - base_seq;
  assign next_inc    = {1'b0, next_seq} + (SEQ_W+1)'(1);
  assign send_now    = (next_seq < total_packets) && (outstanding < SEQ_W'(win));
  assign send_after  = (next_inc < {1'b0, total_packets})
                       && ((outstanding + SEQ_W'(1)) < SEQ_W'(win));
  assign stamp_we    = (state == ST_SEND) && slot_free && send_now;

  assign tx_next        = (transmit_total == {TX_W{1'b1}}) ? transmit_total
                          : transmit_total + TX_W'(1);
  assign ack_total_next = (ack_total == {SEQ_W{1'b1}}) ? ack_total
                          : ack_total + SEQ_W'(1);
  assign rtt_add        = {1'b0, round_trip_sum} + (RTT_W+1)'(rtt);

  // Stamp memory: one write port for sends, one registered read port for acks.
  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[next_seq[SLOT_W-1:0]] <= req_now;
    end
    rd_data <= stamp_mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      total_packets  <= gbn_pkg::TOTAL_RESET;
      win_limit      <= gbn_pkg::WINDOW_RESET;
      base_seq       <= '0;
      next_seq       <= '0;
      transmit_total <= '0;
      ack_total      <= '0;
      round_trip_sum <= '0;
      rd_left        <= '0;
      rd_v           <= 1'b0;
      rtt_v          <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          gbn_pkg::REG_TOTAL:  total_packets <= cfg_data;
          gbn_pkg::REG_WINDOW: win_limit     <= cfg_data[WIN_W-1:0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready && (state != ST_SEND)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_take) begin
            req_now <= in_now;
            ack_end <= in_ack;
            case (in_op)
              gbn_pkg::OP_ACK: begin
                if (ack_ok) begin
                  rd_ptr  <= base_seq[SLOT_W-1:0];
                  rd_left <= ack_span[WIN_W-1:0] + WIN_W'(1);
                end
                state <= ack_ok ? ST_ACK : ST_SEND;
              end
              gbn_pkg::OP_TIMEOUT: begin
                next_seq <= base_seq;
                state    <= ST_SEND;
              end
              default: state <= ST_SEND;
            endcase
          end
        end
        ST_ACK: begin
          // Three-step walk: read the stamp, form the round trip, accumulate.
          if (rd_left != '0) begin
            rd_ptr  <= rd_ptr + SLOT_W'(1);
            rd_left <= rd_left - WIN_W'(1);
          end
          rd_v  <= (rd_left != '0);
          rtt_v <= rd_v;
          if (rd_v) begin
            rtt <= (req_now >= rd_data) ? req_now - rd_data : '0;
          end
          if (rtt_v) begin
            ack_total      <= ack_total_next;
            round_trip_sum <= rtt_add[RTT_W] ? {RTT_W{1'b1}} : rtt_add[RTT_W-1:0];
          end
          if ((rd_left == '0) && !rd_v && !rtt_v) begin
            base_seq <= ack_end + SEQ_W'(1);
            state    <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (slot_free) begin
            m_tvalid <= 1'b1;
            m_tdata[87:64]  <= ack_total;
            m_tdata[150:88] <= round_trip_sum;
            m_tdata[151]    <= (base_seq >= total_packets);
            if (send_now) begin
              transmit_total  <= tx_next;
              next_seq        <= next_inc[SEQ_W-1:0];
              m_tuser         <= 1'b1;
              m_tdata[23:0]   <= next_seq;
              m_tdata[63:24]  <= tx_next;
              m_tlast         <= !send_after;
              if (!send_after) begin
                state <= ST_IDLE;
              end
            end else begin
              m_tuser        <= 1'b0;
              m_tdata[23:0]  <= '0;
              m_tdata[63:24] <= transmit_total;
              m_tlast        <= 1'b1;
              state          <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `GBN_ASSERT(a_window_span, clk, rst,
    (next_seq >= base_seq) && ((next_seq - base_seq) <= SEQ_W'(gbn_pkg::MAX_WINDOW)))
  `GBN_ASSERT_NXT(a_busy_after_take, clk, rst, in_take, state != ST_IDLE)
  `GBN_ASSERT_NXT(a_acks_grow, clk, rst, 1'b1, ack_total >= $past(ack_total))
  `GBN_ASSERT_IMP(a_walk_idle_out, clk, rst, state == ST_ACK, !stamp_we)

endmodule
